// ===== hw/rtl/lant_pkg.sv =====
// Package for the ant stepping block: heading codes and configuration
// register indexes. No dependencies.
package lant_pkg;

  // Heading of the ant; clockwise is one step up the code
  typedef logic [1:0] heading_t;
  localparam heading_t HEAD_UP    = 2'd0;
  localparam heading_t HEAD_RIGHT = 2'd1;
  localparam heading_t HEAD_DOWN  = 2'd2;
  localparam heading_t HEAD_LEFT  = 2'd3;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_GRID_WIDTH    = 2'd0,
    REG_GRID_LENGTH   = 2'd1,
    REG_START_HEADING = 2'd2,
    REG_STEP_BUDGET   = 2'd3
  } cfg_reg_e;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam int SIZE_W     = 9;
  localparam int OUT_POS_W  = 8;

endpackage

// ===== hw/rtl/lant_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. No dependencies.
module lant_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 65536
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write one entry
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Register read data; hold it while no read is issued
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/langton_ant_step.sv =====
// Langton's ant stepping over a one-bit cell map held in a RAM.
// Depends on lant_pkg and lant_ram.
//
//   channel | direction | handshake                  | payload
//   --------+-----------+----------------------------+---------------------------------
//   in      | in        | in_valid_i / in_ready_o    | restart_i
//   out     | out       | out_valid_o / out_ready_i  | flipped_x/y, cell_now, ant_*,
//           |           |                            | done_res
//   cfg     | in        | cfg_we_i (no wait)         | cfg_idx_i, cfg_data_i
//
// Each transaction first reads the cell under the ant, then turns, flips the
// cell, moves and loads the result. The next cell address depends on that
// move, so a new transaction is taken only after the last one completes.
// After reset a clearing pass zeroes all 2**(clog2(MAX_COLS) + clog2(MAX_ROWS))
// map entries (65536 at the defaults), with in_ready_o low.
// A result waiting in the output register does not block the next read; the
// second step stalls only while that register is full and out_ready_i is low.
module langton_ant_step
  import lant_pkg::*;
#(
  parameter int MAX_COLS = 256,
  parameter int MAX_ROWS = 256
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  restart_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [OUT_POS_W-1:0]  flipped_x_o,
  output logic [OUT_POS_W-1:0]  flipped_y_o,
  output logic                  cell_now_o,
  output logic [OUT_POS_W-1:0]  ant_col_o,
  output logic [OUT_POS_W-1:0]  ant_row_o,
  output logic [1:0]            ant_heading_o,
  output logic                  done_res_o
);

  localparam int CW    = $clog2(MAX_COLS);
  localparam int RW    = $clog2(MAX_ROWS);
  localparam int CLW   = CW + 1;
  localparam int RLW   = RW + 1;
  localparam int AW    = CW + RW;
  localparam int DEPTH = 2 ** AW;
  localparam int RST_COLS = (256 > MAX_COLS) ? MAX_COLS : 256;
  localparam int RST_ROWS = (256 > MAX_ROWS) ? MAX_ROWS : 256;
  localparam int RST_COL  = RST_COLS / 2;
  localparam int RST_ROW  = RST_ROWS / 2;

  // Size in use: zero reads as one, above the maximum reads as the maximum
  function automatic logic [31:0] used_size(input logic [SIZE_W-1:0] v, input int maxv);
    logic [31:0] r;
    r = 32'(v);
    if (v == '0) begin
      r = 32'd1;
    end else if (r > 32'(maxv)) begin
      r = 32'(maxv);
    end
    return r;
  endfunction

  // Step a column one way or hold it, then clamp to the last column in use
  function automatic logic [CW-1:0] clamp_col(input logic [CW-1:0] c, input logic inc,
                                              input logic dec, input logic [CLW-1:0] lim);
    logic [CLW-1:0] nx;
    nx = {1'b0, c};
    if (dec) begin
      nx = (nx == '0) ? '0 : nx - 1'b1;
    end else if (inc) begin
      nx = nx + 1'b1;
    end
    if (nx >= lim) begin
      nx = lim - 1'b1;
    end
    return nx[CW-1:0];
  endfunction

  function automatic logic [RW-1:0] clamp_row(input logic [RW-1:0] c, input logic inc,
                                              input logic dec, input logic [RLW-1:0] lim);
    logic [RLW-1:0] nx;
    nx = {1'b0, c};
    if (dec) begin
      nx = (nx == '0) ? '0 : nx - 1'b1;
    end else if (inc) begin
      nx = nx + 1'b1;
    end
    if (nx >= lim) begin
      nx = lim - 1'b1;
    end
    return nx[RW-1:0];
  endfunction

  // Configuration registers
  logic [SIZE_W-1:0] grid_width_q, grid_length_q;
  heading_t          start_heading_q;
  logic [31:0]       step_budget_q;

  // Ant state
  logic [CW-1:0] col_q, col_d;
  logic [RW-1:0] row_q, row_d;
  heading_t      hd_q, hd_d;
  logic [31:0]   steps_q, steps_d;

  // Control
  logic          clr_q;
  logic [AW-1:0] clr_addr_q;
  logic          busy_q, busy_d;
  logic          out_valid_q, out_valid_d;

  // Result register
  logic [OUT_POS_W-1:0] fx_q, fy_q, acol_q, arow_q;
  logic                 cell_q, done_q;
  heading_t             ahd_q;

  logic [CLW-1:0] wlim, cen_col;
  logic [RLW-1:0] llim, cen_row;
  logic           in_acc, complete, done, rd_cell, cell_new;
  logic [CW-1:0]  col_eff, col_mv;
  logic [RW-1:0]  row_eff, row_mv;
  heading_t       hd_new;
  logic           col_inc, col_dec, row_inc, row_dec;
  logic           ram_we, ram_wdata, ram_rdata;
  logic [AW-1:0]  ram_waddr;

  assign wlim    = CLW'(used_size(grid_width_q, MAX_COLS));
  assign llim    = RLW'(used_size(grid_length_q, MAX_ROWS));
  assign cen_col = wlim >> 1;
  assign cen_row = llim >> 1;

  assign in_ready_o = !clr_q && !busy_q;
  assign in_acc     = in_valid_i && in_ready_o;
  assign complete   = busy_q && (!out_valid_q || out_ready_i);

  // Position used for the read: recentred on restart
  assign col_eff = restart_i ? cen_col[CW-1:0] : col_q;
  assign row_eff = restart_i ? cen_row[RW-1:0] : row_q;

  // Turn, flip and move from the cell read when the transaction was accepted
  assign done     = steps_q >= step_budget_q;
  assign rd_cell  = ram_rdata;
  assign hd_new   = rd_cell ? hd_q - 2'd1 : hd_q + 2'd1;
  assign cell_new = ~rd_cell;

  always_comb begin
    col_inc = 1'b0;
    col_dec = 1'b0;
    row_inc = 1'b0;
    row_dec = 1'b0;
    case (hd_new)
      HEAD_UP:    row_dec = 1'b1;
      HEAD_RIGHT: col_inc = 1'b1;
      HEAD_DOWN:  row_inc = 1'b1;
      default:    col_dec = 1'b1;
    endcase
  end

  assign col_mv = clamp_col(col_q, col_inc, col_dec, wlim);
  assign row_mv = clamp_row(row_q, row_inc, row_dec, llim);

  // Next ant state: restart at accept, step at completion unless the step budget is spent
  always_comb begin
    col_d   = col_q;
    row_d   = row_q;
    hd_d    = hd_q;
    steps_d = steps_q;
    busy_d  = busy_q;
    if (in_acc) begin
      busy_d = 1'b1;
      if (restart_i) begin
        col_d   = cen_col[CW-1:0];
        row_d   = cen_row[RW-1:0];
        hd_d    = start_heading_q;
        steps_d = '0;
      end
    end else if (complete) begin
      busy_d = 1'b0;
      if (!done) begin
        col_d   = col_mv;
        row_d   = row_mv;
        hd_d    = hd_new;
        steps_d = steps_q + 32'd1;
      end
    end
  end

  assign out_valid_d = complete ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);

  // Write port: clearing pass or write-back of the flipped cell
  assign ram_we    = clr_q || (complete && !done);
  assign ram_waddr = clr_q ? clr_addr_q : {row_q, col_q};
  assign ram_wdata = clr_q ? 1'b0 : cell_new;

  lant_ram #(
    .WIDTH(1),
    .DEPTH(DEPTH)
  ) u_map (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (in_acc),
    .raddr_i({row_eff, col_eff}),
    .rdata_o(ram_rdata)
  );

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_width_q    <= SIZE_W'(256);
      grid_length_q   <= SIZE_W'(256);
      start_heading_q <= HEAD_UP;
      step_budget_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_GRID_WIDTH:    grid_width_q    <= cfg_data_i[SIZE_W-1:0];
        REG_GRID_LENGTH:   grid_length_q   <= cfg_data_i[SIZE_W-1:0];
        REG_START_HEADING: start_heading_q <= cfg_data_i[1:0];
        REG_STEP_BUDGET:   step_budget_q   <= cfg_data_i;
        default:           ;
      endcase
    end
  end

  // Ant state and control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q       <= CW'(RST_COL);
      row_q       <= RW'(RST_ROW);
      hd_q        <= HEAD_UP;
      steps_q     <= '0;
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
      clr_q       <= 1'b1;
      clr_addr_q  <= '0;
    end else begin
      col_q       <= col_d;
      row_q       <= row_d;
      hd_q        <= hd_d;
      steps_q     <= steps_d;
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
      // Advance the clearing pass until the last entry is written
      if (clr_q) begin
        clr_addr_q <= clr_addr_q + 1'b1;
        if (clr_addr_q == '1) begin
          clr_q <= 1'b0;
        end
      end
    end
  end

  // Load the result register
  always_ff @(posedge clk_i) begin
    if (complete) begin
      if (done) begin
        fx_q   <= '0;
        fy_q   <= '0;
        cell_q <= 1'b0;
        acol_q <= OUT_POS_W'(32'(col_q));
        arow_q <= OUT_POS_W'(32'(row_q));
        ahd_q  <= hd_q;
      end else begin
        fx_q   <= OUT_POS_W'(32'(col_q));
        fy_q   <= OUT_POS_W'(32'(row_q));
        cell_q <= cell_new;
        acol_q <= OUT_POS_W'(32'(col_mv));
        arow_q <= OUT_POS_W'(32'(row_mv));
        ahd_q  <= hd_new;
      end
      done_q <= done;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign flipped_x_o   = fx_q;
  assign flipped_y_o   = fy_q;
  assign cell_now_o    = cell_q;
  assign ant_col_o     = acol_q;
  assign ant_row_o     = arow_q;
  assign ant_heading_o = ahd_q;
  assign done_res_o    = done_q;

endmodule
